// File: rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// shared types and constants of the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

  typedef enum logic [2:0] {
    VERDICT_STORED    = 3'd0,
    VERDICT_COMPLETE  = 3'd1,
    VERDICT_DROPPED   = 3'd2,
    VERDICT_NO_ENTRY  = 3'd3,
    VERDICT_BAD_HDR   = 3'd4,
    VERDICT_SKIPPED   = 3'd5,
    VERDICT_FULL      = 3'd6
  } verdict_t;

  localparam logic [1:0] CFG_MAGIC     = 2'd0;
  localparam logic [1:0] CFG_EXCLUSION = 2'd1;
  localparam logic [1:0] CFG_MAX_SIZE  = 2'd2;

  typedef struct packed {
    logic [47:0] source_key;
    logic        first_in_packet;
    logic [31:0] header_magic;
    logic [31:0] sender_exclusion_id;
    logic [31:0] msg_tag;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_size;
    logic [31:0] total_size;
    logic [15:0] bytes_remaining;
  } frag_hdr_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  slot;
    logic [23:0] write_offset;
    logic [23:0] write_length;
    logic [23:0] message_size;
  } frag_res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

// File: rtl/frt_stream_if.sv
// ----------------------------------------------------------------------------
// frt_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface frt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/frt_ram.sv
// ----------------------------------------------------------------------------
// frt_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/frt_tag_match.sv
// ----------------------------------------------------------------------------
// frt_tag_match
// source tag registers with valid bits, match and free-slot search
// ----------------------------------------------------------------------------
module frt_tag_match #(
  parameter int SOURCES = 8,
  parameter int AW      = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [47:0]   key,
  input  logic          alloc,
  input  logic [AW-1:0] alloc_slot,
  output logic          hit,
  output logic [AW-1:0] hit_slot,
  output logic          free_found,
  output logic [AW-1:0] free_slot
);
  logic [SOURCES-1:0] valid_r;
  logic [47:0]        tag_r [SOURCES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (alloc) begin
      valid_r[alloc_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      tag_r[alloc_slot] <= key;
    end
  end

  // lowest matching and lowest free entry
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SOURCES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == key) begin
        hit      = 1'b1;
        hit_slot = AW'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end
endmodule

// File: rtl/fragment_reassembly_tracker_unit.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_unit
// per-source fragment sequence tracker with ram-held message state
// ----------------------------------------------------------------------------
// usage
//   in  : one decoded fragment header per transfer (valid/ready)
//   out : one verdict per header with slot, write offset/length and size
//   cfg : register writes (magic, exclusion id, max size), only when idle
// timing
//   header accepted -> entry state read from ram -> check and write back,
//   result registered before out valid rises
//   one header at a time; the next header is taken only after the ram read,
//   the read-modify-write of the entry, the result transfer and the cycle
//   in which in ready rises again
// reset
//   all source entries invalid, packet skip cleared, registers to defaults;
//   no clearing pass, entry ram is always written on open
// stall
//   a held result blocks the next header; nothing is lost or repeated
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit #(
  parameter int SOURCES   = 8,
  parameter int SIZE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  frt_stream_if.sink   in_ch,
  frt_stream_if.source out_ch,
  frt_stream_if.sink   cfg_ch
);
  import frt_pkg::*;

  localparam int AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int EW = 32 + 2 * SIZE_BITS;
  localparam logic [32:0] SIZE_LIMIT = 33'((64'd1 << SIZE_BITS) - 64'd1);

  // configuration registers
  logic [31:0] magic_r, excl_r;
  logic [23:0] max_size_r;
  cfg_wr_t     cfg;
  assign cfg          = cfg_ch.payload;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      excl_r     <= '0;
      max_size_r <= 24'hFFFFFF;
    end else if (cfg_ch.valid) begin
      unique case (cfg.index)
        CFG_MAGIC:     magic_r    <= cfg.data;
        CFG_EXCLUSION: excl_r     <= cfg.data;
        CFG_MAX_SIZE:  max_size_r <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // control: busy holds the header while the entry is read
  logic      busy_r, busy_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skip_r, skip_nxt;
  frag_hdr_t hdr_r;
  frag_res_t res_r, res_nxt;

  assign in_ch.ready    = !busy_r && !out_valid_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = res_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // tag match on the held header
  logic          hit, free_found, alloc;
  logic [AW-1:0] hit_slot, free_slot, slot;

  frt_tag_match #(.SOURCES(SOURCES), .AW(AW)) u_tag (
    .clk(clk), .rst_n(rst_n), .key(hdr_r.source_key),
    .alloc(alloc), .alloc_slot(free_slot),
    .hit(hit), .hit_slot(hit_slot),
    .free_found(free_found), .free_slot(free_slot)
  );

  // entry ram: {message id, expected offset, expected total}
  logic          ent_we;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic [AW-1:0] rd_addr;

  assign rd_addr = slot;

  frt_ram #(.WIDTH(EW), .DEPTH(SOURCES)) u_ent_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(slot), .wr_data(ent_wdata),
    .rd_addr(rd_addr), .rd_data(ent_rdata)
  );

  // busy_r: the first phase reads ram at slot (held header); phase_r marks data ready
  logic phase_r, phase_nxt;

  logic [31:0]          e_mid;
  logic [SIZE_BITS-1:0] e_off, e_tot;

  always_comb begin
    logic                 bad;
    logic                 restart;
    logic [31:0]          cur_mid;
    logic [32:0]          cur_off, cur_tot, nxt;
    logic                 ok;
    slot          = hit ? hit_slot : free_slot;
    e_mid         = ent_rdata[EW-1 -: 32];
    e_off         = ent_rdata[2*SIZE_BITS-1 -: SIZE_BITS];
    e_tot         = ent_rdata[SIZE_BITS-1:0];
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    skip_nxt      = skip_r;
    res_nxt       = res_r;
    alloc         = 1'b0;
    ent_we        = 1'b0;
    ent_wdata     = '0;
    bad           = 1'b0;
    restart       = 1'b0;
    cur_mid       = '0;
    cur_off       = '0;
    cur_tot       = '0;
    nxt           = '0;
    ok            = 1'b0;
    if (in_fire) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (busy_r && !phase_r) begin
      phase_nxt = 1'b1; // ram read issued this cycle
    end else if (busy_r && phase_r) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      skip_nxt      = skip_r && !hdr_r.first_in_packet;
      bad = hdr_r.header_magic != magic_r ||
            (excl_r != '0 && excl_r == hdr_r.sender_exclusion_id) ||
            hdr_r.chunk_size > {16'd0, hdr_r.bytes_remaining} ||
            hdr_r.total_size > {8'd0, max_size_r} ||
            {1'b0, hdr_r.total_size} > SIZE_LIMIT;
      if (skip_nxt) begin
        res_nxt.verdict = VERDICT_SKIPPED;
      end else if (bad) begin
        skip_nxt        = 1'b1;
        res_nxt.verdict = VERDICT_BAD_HDR;
      end else if (!hit && hdr_r.chunk_offset != '0) begin
        res_nxt.verdict = VERDICT_NO_ENTRY;
      end else if (!hit && !free_found) begin
        res_nxt.verdict = VERDICT_FULL;
      end else begin
        alloc   = !hit;
        restart = !hit || hdr_r.chunk_offset == '0 || hdr_r.msg_tag != e_mid;
        cur_mid = restart ? hdr_r.msg_tag : e_mid;
        cur_off = restart ? 33'd0 : 33'(e_off);
        cur_tot = restart ? 33'(hdr_r.total_size) : 33'(e_tot);
        nxt     = 33'(hdr_r.chunk_offset) + 33'(hdr_r.chunk_size);
        ok      = 33'(hdr_r.total_size) == cur_tot &&
                  33'(hdr_r.chunk_offset) == cur_off && nxt <= cur_tot;
        ent_we       = 1'b1;
        res_nxt.slot = 6'(slot);
        if (ok) begin
          res_nxt.write_offset = hdr_r.chunk_offset[23:0];
          res_nxt.write_length = hdr_r.chunk_size[23:0];
          res_nxt.message_size = hdr_r.total_size[23:0];
          if (nxt == cur_tot) begin
            res_nxt.verdict = VERDICT_COMPLETE;
            ent_wdata       = {cur_mid, {2*SIZE_BITS{1'b0}}};
          end else begin
            res_nxt.verdict = VERDICT_STORED;
            ent_wdata = {cur_mid, nxt[SIZE_BITS-1:0], cur_tot[SIZE_BITS-1:0]};
          end
        end else begin
          res_nxt.verdict = VERDICT_DROPPED;
          ent_wdata       = {cur_mid, {2*SIZE_BITS{1'b0}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      skip_r      <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      skip_r      <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_r <= in_ch.payload;
    end
    res_r <= res_nxt;
  end

  // the held header is never replaced while it is being worked on
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !in_ch.ready)
    else $error("header accepted while busy");
  // a result appears in the cycle after the finishing phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r) |=> out_valid_r)
    else $error("result missing after entry update");
  // the entry ram is written only in the finishing phase
  assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> (busy_r && phase_r))
    else $error("entry write outside update phase");
endmodule

// File: test/frt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_tb_pkg
// fragment tracking predictor and result scoreboard for the tracker bench
// ----------------------------------------------------------------------------
package frt_tb_pkg;
  import frt_pkg::*;

  class frag_scoreboard;
    localparam int NSRC = 8;
    logic [31:0] magic_word;
    logic [31:0] own_excl;
    logic [23:0] max_size;
    bit          ent_valid [NSRC];
    logic [47:0] ent_key   [NSRC];
    logic [31:0] ent_msg   [NSRC];
    logic [31:0] ent_off   [NSRC];
    logic [31:0] ent_total [NSRC];
    bit          skipping;
    frag_res_t   pending_verdicts[$];
    int          errors;

    function new();
      magic_word = '0;
      own_excl   = '0;
      max_size   = 24'hFFFFFF;
      skipping   = 1'b0;
      errors     = 0;
      foreach (ent_valid[i]) begin
        ent_valid[i] = 1'b0;
        ent_key[i]   = '0;
        ent_msg[i]   = '0;
        ent_off[i]   = '0;
        ent_total[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_MAGIC:     magic_word = data;
        CFG_EXCLUSION: own_excl   = data;
        CFG_MAX_SIZE:  max_size   = data[23:0];
        default: ;
      endcase
    endfunction

    function frag_res_t mk(verdict_t v, int s, logic [31:0] wo, logic [31:0] wl,
                           logic [31:0] ms);
      frag_res_t r;
      r.verdict      = v;
      r.slot         = s[5:0];
      r.write_offset = wo[23:0];
      r.write_length = wl[23:0];
      r.message_size = ms[23:0];
      return r;
    endfunction

    // run one header through the tracker state and queue the verdict
    function void note_header(frag_hdr_t h);
      int slot;
      logic [32:0] next_off;
      slot = -1;
      if (h.first_in_packet) skipping = 1'b0;
      if (skipping) begin
        pending_verdicts.push_back(mk(VERDICT_SKIPPED, 0, 0, 0, 0));
        return;
      end
      if (h.header_magic != magic_word ||
          (own_excl != 0 && own_excl == h.sender_exclusion_id) ||
          h.chunk_size > {16'd0, h.bytes_remaining} ||
          h.total_size > {8'd0, max_size} || h.total_size > 32'hFFFFFF) begin
        skipping = 1'b1;
        pending_verdicts.push_back(mk(VERDICT_BAD_HDR, 0, 0, 0, 0));
        return;
      end
      for (int i = 0; i < NSRC; i++)
        if (slot < 0 && ent_valid[i] && ent_key[i] == h.source_key) slot = i;
      if (slot < 0) begin
        if (h.chunk_offset != 0) begin
          pending_verdicts.push_back(mk(VERDICT_NO_ENTRY, 0, 0, 0, 0));
          return;
        end
        for (int i = 0; i < NSRC; i++)
          if (slot < 0 && !ent_valid[i]) slot = i;
        if (slot < 0) begin
          pending_verdicts.push_back(mk(VERDICT_FULL, 0, 0, 0, 0));
          return;
        end
        ent_valid[slot] = 1'b1;
        ent_key[slot]   = h.source_key;
      end
      if (h.chunk_offset == 0 || h.msg_tag != ent_msg[slot]) begin
        ent_msg[slot]   = h.msg_tag;
        ent_off[slot]   = '0;
        ent_total[slot] = h.total_size;
      end
      next_off = {1'b0, h.chunk_offset} + {1'b0, h.chunk_size};
      if (h.total_size == ent_total[slot] && h.chunk_offset == ent_off[slot] &&
          next_off <= {1'b0, ent_total[slot]}) begin
        if (next_off == {1'b0, ent_total[slot]}) begin
          ent_off[slot]   = '0;
          ent_total[slot] = '0;
          pending_verdicts.push_back(mk(VERDICT_COMPLETE, slot, h.chunk_offset,
                                        h.chunk_size, h.total_size));
        end else begin
          ent_off[slot] = next_off[31:0];
          pending_verdicts.push_back(mk(VERDICT_STORED, slot, h.chunk_offset,
                                        h.chunk_size, h.total_size));
        end
        return;
      end
      ent_off[slot]   = '0;
      ent_total[slot] = '0;
      pending_verdicts.push_back(mk(VERDICT_DROPPED, slot, 0, 0, 0));
    endfunction

    function void check_verdict(frag_res_t got);
      frag_res_t exp_r;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_r = pending_verdicts.pop_front();
      if (got.verdict !== exp_r.verdict) begin
        $error("verdict: expected %0d actual %0d", exp_r.verdict, got.verdict);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d actual %0d", exp_r.slot, got.slot);
        errors++;
      end
      if (got.write_offset !== exp_r.write_offset) begin
        $error("write_offset: expected %0d actual %0d", exp_r.write_offset,
               got.write_offset);
        errors++;
      end
      if (got.write_length !== exp_r.write_length) begin
        $error("write_length: expected %0d actual %0d", exp_r.write_length,
               got.write_length);
        errors++;
      end
      if (got.message_size !== exp_r.message_size) begin
        $error("message_size: expected %0d actual %0d", exp_r.message_size,
               got.message_size);
        errors++;
      end
    endfunction
  endclass
endpackage

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives fragment headers and register writes into the reassembly tracker,
// predicts every verdict and checks it as the result transfers complete
// ----------------------------------------------------------------------------
module testbench;
  import frt_pkg::*;
  import frt_tb_pkg::*;

  logic clk;
  logic rst_n;

  frt_stream_if #(.payload_t(frag_hdr_t)) in_if ();
  frt_stream_if #(.payload_t(frag_res_t)) out_if ();
  frt_stream_if #(.payload_t(cfg_wr_t))   cfg_if ();

  fragment_reassembly_tracker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  frag_scoreboard tracker_sb;
  bit  quiet_tail;      // last part of the run: no idling anywhere
  bit  hold_off_req;    // ask the receiver for one long stall
  int  hdr_count;

  // small pool of sources so entries are reused; ten keys overflow the table
  logic [47:0] key_pool [10];
  logic [31:0] cur_magic;
  logic [31:0] cur_excl;
  logic [23:0] cur_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("fragment_reassembly_tracker_unit regression: fail");
    $finish;
  end

  // one header transfer, with an optional random idle burst in front
  task automatic send_header(frag_hdr_t h);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= h;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker_sb.note_header(h);
    hdr_count++;
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high across back to back writes; set_regs drops it
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= idx;
    cfg_if.payload.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker_sb.write_reg(idx, data);
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    idle_input();
    while (tracker_sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] m, logic [31:0] x, logic [23:0] s);
    drain();
    write_reg(CFG_MAGIC, m);
    write_reg(CFG_EXCLUSION, x);
    write_reg(CFG_MAX_SIZE, {8'd0, s});
    cfg_if.valid <= 1'b0;
    cur_magic = m;
    cur_excl  = x;
    cur_max   = s;
  endtask

  function automatic frag_hdr_t good_hdr(logic [47:0] key, logic [31:0] mid,
                                         logic [31:0] off, logic [31:0] csz,
                                         logic [31:0] tot, bit first);
    frag_hdr_t h;
    h.source_key          = key;
    h.first_in_packet     = first;
    h.header_magic        = cur_magic;
    h.sender_exclusion_id = (cur_excl == 0) ? $urandom : cur_excl ^ (1 << $urandom_range(0, 31));
    h.msg_tag             = mid;
    h.chunk_offset        = off;
    h.chunk_size          = csz;
    h.total_size          = tot;
    h.bytes_remaining     = 16'(csz + $urandom_range(0, 3));
    return h;
  endfunction

  // a message split into chunks, some corrupted; the sequence may end early
  task automatic send_message(logic [47:0] key);
    logic [31:0] mid;
    logic [31:0] tot;
    logic [31:0] off;
    logic [31:0] csz;
    frag_hdr_t h;
    mid = $urandom;
    tot = ($urandom_range(0, 15) == 0) ? {8'd0, cur_max} : $urandom_range(0, 200);
    if (tot > {8'd0, cur_max}) tot = {8'd0, cur_max};
    off = 0;
    do begin
      csz = $urandom_range(1, 60);
      if (off + csz > tot) csz = tot - off;
      if (csz > 32'hFFF0) csz = 32'hFFF0;
      h = good_hdr(key, mid, off, csz, tot, $urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: h.chunk_offset = off + 1;
        1: h.total_size = tot + 1;
        2: h.msg_tag = mid + 1;
        3: h.header_magic = ~cur_magic;
        4: h.chunk_size = h.bytes_remaining + 1;
        default: ;
      endcase
      send_header(h);
      off = off + csz;
    end while (off < tot && $urandom_range(0, 30) != 0);
  endtask

  function automatic frag_hdr_t noise_hdr();
    frag_hdr_t h;
    h = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    h.source_key = ($urandom_range(0, 1)) ? key_pool[$urandom_range(0, 9)] :
                   48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) h.header_magic = cur_magic;
    if ($urandom_range(0, 1)) h.chunk_offset = 0;
    return h;
  endfunction

  // receiver: random stalls, plus one long hold-off while headers keep coming
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        for (stall = 0; stall < 300; stall++) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor: check on every completed result transfer
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker_sb.check_verdict(out_if.payload);
  end

  initial begin
    frag_hdr_t h;
    int wait_cycles;
    tracker_sb   = new();
    quiet_tail   = 1'b0;
    hold_off_req = 1'b0;
    hdr_count    = 0;
    cur_magic = '0;
    cur_excl  = '0;
    cur_max   = 24'hFFFFFF;
    foreach (key_pool[i]) key_pool[i] = 48'({$urandom, $urandom});
    key_pool[9] = 48'hFFFF_FFFF_FFFF;
    key_pool[8] = 48'h0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, then extremes and each special case
    send_header(good_hdr(key_pool[0], 32'hFFFFFFFF, 0, 0, 0, 1)); // zero-size message
    send_header(good_hdr(key_pool[0], 1, 0, 10, 30, 0));
    send_header(good_hdr(key_pool[0], 1, 10, 10, 30, 0));
    send_header(good_hdr(key_pool[0], 1, 20, 10, 30, 0));         // completes
    send_header(good_hdr(key_pool[1], 2, 5, 5, 30, 0));           // no entry
    send_header(good_hdr(key_pool[0], 3, 0, 10, 30, 0));
    send_header(good_hdr(key_pool[0], 3, 15, 10, 30, 0));         // out of order
    send_header(good_hdr(key_pool[0], 4, 0, 10, 30, 0));
    send_header(good_hdr(key_pool[0], 5, 10, 10, 30, 0));         // new id mid-way
    h = good_hdr(key_pool[2], 6, 0, 16'hFFFF, 24'hFFFFFF, 0);
    h.bytes_remaining = 16'hFFFF;
    send_header(h);
    h = good_hdr(key_pool[2], 7, 0, 5, 32'h0100_0000, 0);         // above size limit
    send_header(h);
    send_header(good_hdr(key_pool[2], 7, 0, 5, 10, 0));           // skipped
    send_header(good_hdr(key_pool[2], 7, 0, 5, 10, 1));           // new packet
    h = good_hdr(key_pool[3], 8, 0, 5, 10, 1);
    h.chunk_size = h.bytes_remaining + 1;
    send_header(h);
    h = good_hdr(key_pool[3], 8, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send_header(h);
    for (int k = 3; k < 10; k++) send_header(good_hdr(key_pool[k], k, 0, 1, 4, 1));

    set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 24'd0);
    h = good_hdr(key_pool[4], 9, 0, 0, 0, 1);
    send_header(h);
    h.sender_exclusion_id = 32'hFFFFFFFF;                          // excluded id
    h.first_in_packet     = 1'b1;
    send_header(h);
    h = good_hdr(key_pool[4], 9, 0, 0, 1, 1);                     // above max size
    send_header(h);

    // random phases across register settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs($urandom, 32'd0, 24'hFFFFFF);
        1: set_regs(32'd0, $urandom, 24'd100);
        2: set_regs($urandom, $urandom, 24'($urandom_range(1, 24'hFFFFFF)));
        3: set_regs(32'hA5A5_5A5A, 32'd1, 24'd255);
        4: set_regs($urandom, 32'd0, 24'hFFFFFF);
        default: set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
      endcase
      if (phase == 2) hold_off_req = 1'b1;
      if (phase == 5) quiet_tail = 1'b1;
      while (hdr_count < 25 + (phase + 1) * 250) begin
        if ($urandom_range(0, 7) == 0) send_header(noise_hdr());
        else send_message(key_pool[$urandom_range(0, 9)]);
      end
    end
    idle_input();

    wait_cycles = 0;
    while (tracker_sb.pending_verdicts.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (tracker_sb.errors == 0 && tracker_sb.pending_verdicts.size() == 0) begin
      $display("fragment_reassembly_tracker_unit regression: pass");
    end else begin
      $display("fragment_reassembly_tracker_unit regression: fail");
    end
    $finish;
  end
endmodule
